// ----- rtl/lbct_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the LRU block tag store.
package lbct_pkg;

  // Store geometry
  localparam int SLOTS        = 16;
  localparam int CHANNEL_BITS = 6;
  localparam int BLOCK_BITS   = 32;

  // Derived widths
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;
  localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Result kind codes
  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_EVICT  = 1'b1;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_LOAD   = 2'd1,
    OP_TRIM   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // Datapath commands, one per cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_MATCH,
    DP_PROMOTE,
    DP_FAIL,
    DP_EVICT,
    DP_INSERT,
    DP_CLR_EMIT,
    DP_CLR_DONE,
    DP_DONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    op_e  op;
    logic fetch_ok;
    logic evict_load;
    logic evict_trim;
    logic clear_more;
  } dp_status_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RUN
  } state_e;

endpackage

// ----- rtl/lru_block_cache_tags.sv -----
// Top level of the fully associative LRU block tag store.
// Sequence: the request is latched in ST_IDLE, compared against every entry in ST_MATCH, then
// ST_RUN emits any eviction notices one beat at a time and the final answer last; each beat is
// registered. A new request is taken only once the previous one is done: busy stays high until
// the answer beat is registered.
// Results are strobed by valid_o for one cycle each; the receiver cannot stall.
// Reset empties the store and sets capacity to 16 blocks at once; no clearing pass.
module lru_block_cache_tags (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        op_i,
  input  logic [lbct_pkg::CHANNEL_BITS-1:0] channel_i,
  input  logic [lbct_pkg::BLOCK_BITS-1:0]   block_index_i,
  input  logic                              fetch_ok_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lbct_pkg::CAP_W-1:0]        cfg_data_i,
  output logic                              valid_o,
  output logic                              kind_o,
  output logic                              hit_o,
  output logic                              failed_o,
  output logic [lbct_pkg::SLOT_W-1:0]       slot_o,
  output logic [lbct_pkg::CHANNEL_BITS-1:0] out_channel_o,
  output logic [lbct_pkg::BLOCK_BITS-1:0]   out_block_o,
  output logic                              last_o
);
  import lbct_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Capacity writes are always taken
  assign cfg_ready_o = 1'b1;

  lbct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  lbct_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .op_i          (op_i),
    .channel_i     (channel_i),
    .block_index_i (block_index_i),
    .fetch_ok_i    (fetch_ok_i),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .valid_o       (valid_o),
    .kind_o        (kind_o),
    .hit_o         (hit_o),
    .failed_o      (failed_o),
    .slot_o        (slot_o),
    .out_channel_o (out_channel_o),
    .out_block_o   (out_block_o),
    .last_o        (last_o)
  );

endmodule

// ----- rtl/lbct_ctrl.sv -----
// Controller state machine that sequences lookups, loads, trims and clears.
module lbct_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  lbct_pkg::dp_status_t status_i,
  output lbct_pkg::dp_cmd_t    cmd_o
);
  import lbct_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = DP_NOP;
    busy      = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.op = DP_LATCH;
          state_d  = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd_o.op = DP_MATCH;
        state_d  = ST_RUN;
      end
      ST_RUN: begin
        case (status_i.op)
          OP_LOOKUP, OP_LOAD: begin
            if (status_i.hit) begin
              cmd_o.op = DP_PROMOTE;
              state_d  = ST_IDLE;
            end else if (status_i.op == OP_LOOKUP || !status_i.fetch_ok) begin
              cmd_o.op = DP_FAIL;
              state_d  = ST_IDLE;
            end else if (status_i.evict_load) begin
              // make room one beat at a time
              cmd_o.op = DP_EVICT;
            end else begin
              cmd_o.op = DP_INSERT;
              state_d  = ST_IDLE;
            end
          end
          OP_TRIM: begin
            if (status_i.evict_trim) begin
              cmd_o.op = DP_EVICT;
            end else begin
              cmd_o.op = DP_DONE;
              state_d  = ST_IDLE;
            end
          end
          OP_CLEAR: begin
            if (status_i.clear_more) begin
              cmd_o.op = DP_CLR_EMIT;
            end else begin
              cmd_o.op = DP_CLR_DONE;
              state_d  = ST_IDLE;
            end
          end
          default: begin
            cmd_o.op = DP_DONE;
            state_d  = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lbct_dp.sv -----
// Datapath: tag entries, recency ranks, capacity register and registered result beat.
module lbct_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lbct_pkg::dp_cmd_t                 cmd_i,
  output lbct_pkg::dp_status_t              status_o,
  input  logic [1:0]                        op_i,
  input  logic [lbct_pkg::CHANNEL_BITS-1:0] channel_i,
  input  logic [lbct_pkg::BLOCK_BITS-1:0]   block_index_i,
  input  logic                              fetch_ok_i,
  input  logic                              cfg_valid_i,
  input  logic [lbct_pkg::CAP_W-1:0]        cfg_data_i,
  output logic                              valid_o,
  output logic                              kind_o,
  output logic                              hit_o,
  output logic                              failed_o,
  output logic [lbct_pkg::SLOT_W-1:0]       slot_o,
  output logic [lbct_pkg::CHANNEL_BITS-1:0] out_channel_o,
  output logic [lbct_pkg::BLOCK_BITS-1:0]   out_block_o,
  output logic                              last_o
);
  import lbct_pkg::*;

  // Request registers
  op_e                     op_q;
  logic                    ok_q;
  logic [CHANNEL_BITS-1:0] key_ch_q;
  logic [BLOCK_BITS-1:0]   key_blk_q;
  logic                    hit_q;
  logic [SLOT_W-1:0]       hit_slot_q;

  // Tag store
  logic [SLOTS-1:0]        valid_q;
  logic [CHANNEL_BITS-1:0] ch_q   [SLOTS];
  logic [BLOCK_BITS-1:0]   blk_q  [SLOTS];
  logic [SLOT_W-1:0]       rank_q [SLOTS];
  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        clr_rank_q;
  logic [CAP_W-1:0]        cap_q;

  // Result beat registers
  logic                    out_valid_q;
  logic                    out_kind_q;
  logic                    out_hit_q;
  logic                    out_failed_q;
  logic [SLOT_W-1:0]       out_slot_q;
  logic [CHANNEL_BITS-1:0] out_ch_q;
  logic [BLOCK_BITS-1:0]   out_blk_q;
  logic                    out_last_q;

  // Combinational helpers
  logic [SLOTS-1:0]        match_vec;
  logic [SLOT_W-1:0]       match_slot;
  logic [SLOTS-1:0]        sel_vec;
  logic [SLOT_W-1:0]       sel_slot;
  logic [SLOT_W-1:0]       free_slot;
  logic [SLOT_W-1:0]       target_rank;
  logic [CNT_W-1:0]        count_m1;
  logic [SLOT_W-1:0]       promote_rank;
  logic [CMP_W-1:0]        cap_ext;
  logic [CMP_W-1:0]        cnt_ext;
  logic [CMP_W-1:0]        limit;

  logic                    emit;
  logic                    emit_kind;
  logic                    emit_hit;
  logic                    emit_failed;
  logic [SLOT_W-1:0]       emit_slot;
  logic [CHANNEL_BITS-1:0] emit_ch;
  logic [BLOCK_BITS-1:0]   emit_blk;
  logic                    emit_last;

  // Compare the request key against every entry
  always_comb begin
    match_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = valid_q[i] && (ch_q[i] == key_ch_q) && (blk_q[i] == key_blk_q);
      if (match_vec[i]) begin
        match_slot = SLOT_W'(i);
      end
    end
  end

  // Pick the entry of a given rank: least recent for eviction, next rank for clear
  assign count_m1    = count_q - CNT_W'(1);
  assign target_rank = (op_q == OP_CLEAR) ? clr_rank_q[SLOT_W-1:0] : count_m1[SLOT_W-1:0];

  always_comb begin
    sel_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sel_vec[i] = valid_q[i] && (rank_q[i] == target_rank);
      if (sel_vec[i]) begin
        sel_slot = SLOT_W'(i);
      end
    end
  end

  // Lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign promote_rank = rank_q[hit_slot_q];

  // Load limit: capacity clipped to the slot count, at least one
  assign cap_ext = CMP_W'(cap_q);
  assign cnt_ext = CMP_W'(count_q);

  always_comb begin
    if (cap_ext >= CMP_W'(SLOTS)) begin
      limit = CMP_W'(SLOTS);
    end else if (cap_q == '0) begin
      limit = CMP_W'(1);
    end else begin
      limit = cap_ext;
    end
  end

  // Status toward the controller
  always_comb begin
    status_o.hit        = hit_q;
    status_o.op         = op_q;
    status_o.fetch_ok   = ok_q;
    status_o.evict_load = (cnt_ext >= limit);
    status_o.evict_trim = (cnt_ext > cap_ext);
    status_o.clear_more = (clr_rank_q < count_q);
  end

  // Build the result beat for this command
  always_comb begin
    emit        = 1'b0;
    emit_kind   = KIND_ANSWER;
    emit_hit    = 1'b0;
    emit_failed = 1'b0;
    emit_slot   = '0;
    emit_ch     = '0;
    emit_blk    = '0;
    emit_last   = 1'b1;
    case (cmd_i.op)
      DP_PROMOTE: begin
        emit      = 1'b1;
        emit_hit  = 1'b1;
        emit_slot = hit_slot_q;
      end
      DP_FAIL: begin
        emit        = 1'b1;
        emit_failed = 1'b1;
      end
      DP_INSERT: begin
        emit      = 1'b1;
        emit_slot = free_slot;
      end
      DP_EVICT, DP_CLR_EMIT: begin
        emit      = 1'b1;
        emit_kind = KIND_EVICT;
        emit_slot = sel_slot;
        emit_ch   = ch_q[sel_slot];
        emit_blk  = blk_q[sel_slot];
        emit_last = 1'b0;
      end
      DP_CLR_DONE, DP_DONE: begin
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control state: valid bits, count, capacity, clear cursor, request op, hit flag, beat strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      cap_q       <= CAP_W'(CAP_RESET);
      clr_rank_q  <= '0;
      op_q        <= OP_LOOKUP;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= emit;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      case (cmd_i.op)
        DP_LATCH: begin
          op_q       <= op_e'(op_i);
          clr_rank_q <= '0;
        end
        DP_MATCH: begin
          hit_q <= |match_vec;
        end
        DP_EVICT: begin
          valid_q[sel_slot] <= 1'b0;
          count_q           <= count_m1;
        end
        DP_INSERT: begin
          valid_q[free_slot] <= 1'b1;
          count_q            <= count_q + CNT_W'(1);
        end
        DP_CLR_EMIT: begin
          clr_rank_q <= clr_rank_q + CNT_W'(1);
        end
        DP_CLR_DONE: begin
          valid_q <= '0;
          count_q <= '0;
        end
        default: begin
          hit_q <= hit_q;
        end
      endcase
    end
  end

  // Payload: request key, fetch flag, hit slot, entry contents, ranks, result fields
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q   <= emit_kind;
      out_hit_q    <= emit_hit;
      out_failed_q <= emit_failed;
      out_slot_q   <= emit_slot;
      out_ch_q     <= emit_ch;
      out_blk_q    <= emit_blk;
      out_last_q   <= emit_last;
    end
    case (cmd_i.op)
      DP_LATCH: begin
        ok_q      <= fetch_ok_i;
        key_ch_q  <= channel_i;
        key_blk_q <= block_index_i;
      end
      DP_MATCH: begin
        hit_slot_q <= match_slot;
      end
      DP_PROMOTE: begin
        // age everything more recent than the hit, then make the hit most recent
        for (int i = 0; i < SLOTS; i++) begin
          if (valid_q[i] && (rank_q[i] < promote_rank)) begin
            rank_q[i] <= rank_q[i] + SLOT_W'(1);
          end
        end
        rank_q[hit_slot_q] <= '0;
      end
      DP_INSERT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (valid_q[i]) begin
            rank_q[i] <= rank_q[i] + SLOT_W'(1);
          end
        end
        rank_q[free_slot] <= '0;
        ch_q[free_slot]   <= key_ch_q;
        blk_q[free_slot]  <= key_blk_q;
      end
      default: begin
        ok_q <= ok_q;
      end
    endcase
  end

  assign valid_o       = out_valid_q;
  assign kind_o        = out_kind_q;
  assign hit_o         = out_hit_q;
  assign failed_o      = out_failed_q;
  assign slot_o        = out_slot_q;
  assign out_channel_o = out_ch_q;
  assign out_block_o   = out_blk_q;
  assign last_o        = out_last_q;

endmodule

// ----- rtl/lbct_chk.sv -----
// Port-level checker for the LRU block tag store and its bind to the top level.
module lbct_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o,
  input logic hit_o,
  input logic failed_o,
  input logic last_o
);

  // An accepted request gives no beat in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !valid_o)
    else $error("beat right after request accept");

  // The answer beat shows once the block is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy)
    else $error("answer beat while still busy");

  // An eviction notice is always followed by more work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> busy)
    else $error("eviction notice while idle");

  // Busy only rises after a start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // A hit answer never reports failure and is always the last beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hit_o) |-> (!failed_o && last_o))
    else $error("hit beat malformed");

endmodule

bind lru_block_cache_tags lbct_chk u_lbct_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .valid_o  (valid_o),
  .hit_o    (hit_o),
  .failed_o (failed_o),
  .last_o   (last_o)
);
